// ----- design/mmd_pkg.sv -----
// ----------------------------------------------------------------------------
// mmd_pkg
// Shared types and constants for the min/max decimator.
// ----------------------------------------------------------------------------
package mmd_pkg;

  localparam int SAMPLE_WIDTH_DEF   = 16;
  localparam int POSITION_WIDTH_DEF = 24;
  localparam int COUNT_WIDTH        = 16;
  localparam int REG_INDEX_WIDTH    = 3;
  localparam int BURST_DEPTH        = 3;

  typedef enum logic [2:0] {
    KIND_FIRST    = 3'd0,
    KIND_MIN      = 3'd1,
    KIND_MAX      = 3'd2,
    KIND_BOUNDARY = 3'd3,
    KIND_PASS     = 3'd4
  } kind_t;

  typedef enum logic [REG_INDEX_WIDTH-1:0] {
    REG_AGGREGATE_MODE   = 3'd0,
    REG_SAMPLES_UNSIGNED = 3'd1,
    REG_BUCKET_COUNT     = 3'd2,
    REG_STEP_WHOLE       = 3'd3,
    REG_STEP_REMAINDER   = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic                   aggregate_mode;
    logic                   samples_unsigned;
    logic [COUNT_WIDTH-1:0] bucket_count;
    logic [COUNT_WIDTH-1:0] step_remainder;
  } cfg_t;

  typedef struct packed {
    logic [1:0]             count;
    kind_t [BURST_DEPTH-1:0] kind;
    logic [BURST_DEPTH-1:0] last;
  } burst_ctl_t;

endpackage

// ----- design/mmd_if.sv -----
// ----------------------------------------------------------------------------
// mmd_if
// Valid/ready channels for samples in and decimated results out.
// ----------------------------------------------------------------------------
interface mmd_sample_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                    valid;
  logic                    ready;
  logic [SAMPLE_WIDTH-1:0] sample;
  logic                    end_of_stream;

  modport source (output valid, output sample, output end_of_stream, input ready);
  modport sink   (input valid, input sample, input end_of_stream, output ready);
endinterface

interface mmd_result_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                    valid;
  logic                    ready;
  logic [SAMPLE_WIDTH-1:0] value;
  logic [2:0]              kind;
  logic                    last;

  modport source (output valid, output value, output kind, output last, input ready);
  modport sink   (input valid, input value, input kind, input last, output ready);
endinterface

// ----- design/mmd_core.sv -----
// ----------------------------------------------------------------------------
// mmd_core
// Window state, boundary generation and min/max tracking, one sample a cycle given room.
// ----------------------------------------------------------------------------
module mmd_core #(
  parameter int SAMPLE_WIDTH   = 16,
  parameter int POSITION_WIDTH = 24
) (
  input  logic                              clk,
  input  logic                              rst,
  mmd_sample_if.sink                        samples,
  input  mmd_pkg::cfg_t                     cfg,
  input  logic [POSITION_WIDTH-1:0]         step_whole,
  input  logic                              room,
  output mmd_pkg::burst_ctl_t               ctl,
  output logic [mmd_pkg::BURST_DEPTH-1:0][SAMPLE_WIDTH-1:0] values
);
  import mmd_pkg::*;

  localparam logic [SAMPLE_WIDTH-1:0] SignBit = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  logic [POSITION_WIDTH-1:0] position, position_next;
  logic [POSITION_WIDTH-1:0] boundary_whole, boundary_whole_next;
  logic [COUNT_WIDTH-1:0]    boundary_remainder, boundary_remainder_next;
  logic [COUNT_WIDTH-1:0]    bucket_index, bucket_index_next;
  logic [SAMPLE_WIDTH-1:0]   running_min, running_min_next;
  logic [SAMPLE_WIDTH-1:0]   running_max, running_max_next;
  logic                      started, started_next;
  logic                      finished, finished_next;

  logic                      fire;
  logic [POSITION_WIDTH-1:0] base_whole, adv_whole, rounded;
  logic [COUNT_WIDTH-1:0]    base_rem, step_rem, adv_rem;
  logic [COUNT_WIDTH:0]      rem_sum, twice;
  logic                      rem_wrap, round_up, at_boundary, is_last;
  logic [SAMPLE_WIDTH-1:0]   s, key_s, key_min, key_max, flip;

  assign samples.ready = room;
  assign fire          = samples.valid && room;
  assign s             = samples.sample;

  // boundary advance, from zero at window start
  always_comb begin
    base_whole = started ? boundary_whole : '0;
    base_rem   = started ? boundary_remainder : '0;
    if (cfg.bucket_count != '0 && cfg.step_remainder >= cfg.bucket_count) begin
      step_rem = cfg.bucket_count - 1'b1;
    end else begin
      step_rem = cfg.step_remainder;
    end
    rem_sum  = {1'b0, base_rem} + {1'b0, step_rem};
    rem_wrap = rem_sum >= {1'b0, cfg.bucket_count};
    if (rem_wrap) begin
      adv_rem = COUNT_WIDTH'(rem_sum - {1'b0, cfg.bucket_count});
    end else begin
      adv_rem = rem_sum[COUNT_WIDTH-1:0];
    end
    adv_whole = base_whole + step_whole + POSITION_WIDTH'(rem_wrap);
  end

  // round to nearest, ties to even
  always_comb begin
    twice    = {boundary_remainder, 1'b0};
    round_up = (twice > {1'b0, cfg.bucket_count}) ||
               (twice == {1'b0, cfg.bucket_count} && twice != '0 && boundary_whole[0]);
    rounded     = boundary_whole + POSITION_WIDTH'(round_up);
    at_boundary = position >= rounded;
    is_last     = bucket_index >= cfg.bucket_count;
  end

  always_comb begin
    flip    = cfg.samples_unsigned ? '0 : SignBit;
    key_s   = s ^ flip;
    key_min = running_min ^ flip;
    key_max = running_max ^ flip;
  end

  always_comb begin
    position_next           = position;
    boundary_whole_next     = boundary_whole;
    boundary_remainder_next = boundary_remainder;
    bucket_index_next       = bucket_index;
    running_min_next        = running_min;
    running_max_next        = running_max;
    started_next            = started;
    finished_next           = finished;
    ctl                     = '0;
    values                  = '0;
    if (fire) begin
      if (!cfg.aggregate_mode) begin
        ctl.count   = 2'd1;
        ctl.kind[0] = KIND_PASS;
        ctl.last[0] = samples.end_of_stream;
        values[0]   = s;
      end else if (finished) begin
        ctl.count = 2'd0;
      end else if (!started) begin
        started_next            = 1'b1;
        running_min_next        = s;
        running_max_next        = s;
        position_next           = POSITION_WIDTH'(1);
        boundary_whole_next     = '0;
        boundary_remainder_next = '0;
        ctl.count               = 2'd1;
        ctl.kind[0]             = KIND_FIRST;
        values[0]               = s;
        if (cfg.bucket_count == '0) begin
          finished_next = 1'b1;
          ctl.last[0]   = 1'b1;
        end else begin
          bucket_index_next       = COUNT_WIDTH'(1);
          boundary_whole_next     = adv_whole;
          boundary_remainder_next = adv_rem;
        end
      end else if (at_boundary) begin
        ctl.count        = 2'd3;
        ctl.kind[0]      = KIND_MIN;
        ctl.kind[1]      = KIND_MAX;
        ctl.kind[2]      = KIND_BOUNDARY;
        ctl.last[2]      = is_last;
        values[0]        = running_min;
        values[1]        = running_max;
        values[2]        = s;
        running_min_next = s;
        running_max_next = s;
        position_next    = position + 1'b1;
        if (is_last) begin
          finished_next = 1'b1;
        end else begin
          bucket_index_next       = bucket_index + 1'b1;
          boundary_whole_next     = adv_whole;
          boundary_remainder_next = adv_rem;
        end
      end else begin
        if (key_s < key_min) begin
          running_min_next = s;
        end
        if (key_s > key_max) begin
          running_max_next = s;
        end
        position_next = position + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position           <= '0;
      boundary_whole     <= '0;
      boundary_remainder <= '0;
      bucket_index       <= '0;
      running_min        <= '0;
      running_max        <= '0;
      started            <= 1'b0;
      finished           <= 1'b0;
    end else begin
      position           <= position_next;
      boundary_whole     <= boundary_whole_next;
      boundary_remainder <= boundary_remainder_next;
      bucket_index       <= bucket_index_next;
      running_min        <= running_min_next;
      running_max        <= running_max_next;
      started            <= started_next;
      finished           <= finished_next;
    end
  end

endmodule

// ----- design/mmd_out.sv -----
// ----------------------------------------------------------------------------
// mmd_out
// Result register holding up to three results, shifted out one per transfer.
// ----------------------------------------------------------------------------
module mmd_out #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  mmd_result_if.source        results,
  input  mmd_pkg::burst_ctl_t ctl,
  input  logic [mmd_pkg::BURST_DEPTH-1:0][SAMPLE_WIDTH-1:0] values,
  output logic                room
);
  import mmd_pkg::*;

  logic [1:0]                                remaining;
  kind_t [BURST_DEPTH-1:0]                   kind_q;
  logic [BURST_DEPTH-1:0]                    last_q;
  logic [BURST_DEPTH-1:0][SAMPLE_WIDTH-1:0]  value_q;
  logic                                      xfer;

  assign xfer          = results.valid && results.ready;
  assign room          = (remaining == 2'd0) || (remaining == 2'd1 && results.ready);
  assign results.valid = remaining != 2'd0;
  assign results.value = value_q[0];
  assign results.kind  = kind_q[0];
  assign results.last  = last_q[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= 2'd0;
    end else if (room) begin
      remaining <= ctl.count;
    end else if (xfer) begin
      remaining <= remaining - 1'b1;
    end
  end

  // load a new burst, else shift on transfer
  always_ff @(posedge clk) begin
    if (room) begin
      kind_q  <= ctl.kind;
      last_q  <= ctl.last;
      value_q <= values;
    end else if (xfer) begin
      kind_q[0]  <= kind_q[1];
      kind_q[1]  <= kind_q[2];
      last_q[0]  <= last_q[1];
      last_q[1]  <= last_q[2];
      value_q[0] <= value_q[1];
      value_q[1] <= value_q[2];
    end
  end

endmodule

// ----- design/min_max_decimator.sv -----
// ----------------------------------------------------------------------------
// min_max_decimator
// Min/max decimation of one window of samples, with a passthrough mode.
// ----------------------------------------------------------------------------
// Latency: a result is shown in the cycle after its sample's transfer.
// Throughput: one sample per cycle while results are taken; a boundary sample
// gives three results, and the single result register holds off the next
// sample until the last goes out; samples in a bucket give no result or wait.
// Reset: synchronous; clears the window state and loads register defaults.
module min_max_decimator #(
  parameter int SAMPLE_WIDTH   = mmd_pkg::SAMPLE_WIDTH_DEF,
  parameter int POSITION_WIDTH = mmd_pkg::POSITION_WIDTH_DEF,
  localparam int CfgWidth = (POSITION_WIDTH > mmd_pkg::COUNT_WIDTH) ?
                            POSITION_WIDTH : mmd_pkg::COUNT_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [mmd_pkg::REG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [CfgWidth-1:0]                  cfg_data,
  mmd_sample_if.sink                           samples,
  mmd_result_if.source                         results
);
  import mmd_pkg::*;

  cfg_t                                     cfg;
  logic [POSITION_WIDTH-1:0]                step_whole;
  logic                                     room;
  burst_ctl_t                               ctl;
  logic [BURST_DEPTH-1:0][SAMPLE_WIDTH-1:0] values;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.aggregate_mode   <= 1'b1;
      cfg.samples_unsigned <= 1'b0;
      cfg.bucket_count     <= COUNT_WIDTH'(1);
      cfg.step_remainder   <= '0;
      step_whole           <= POSITION_WIDTH'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_AGGREGATE_MODE:   cfg.aggregate_mode   <= cfg_data[0];
        REG_SAMPLES_UNSIGNED: cfg.samples_unsigned <= cfg_data[0];
        REG_BUCKET_COUNT:     cfg.bucket_count     <= cfg_data[COUNT_WIDTH-1:0];
        REG_STEP_WHOLE:       step_whole           <= cfg_data[POSITION_WIDTH-1:0];
        REG_STEP_REMAINDER:   cfg.step_remainder   <= cfg_data[COUNT_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  mmd_core #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .samples    (samples),
    .cfg        (cfg),
    .step_whole (step_whole),
    .room       (room),
    .ctl        (ctl),
    .values     (values)
  );

  mmd_out #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_out (
    .clk     (clk),
    .rst     (rst),
    .results (results),
    .ctl     (ctl),
    .values  (values),
    .room    (room)
  );

endmodule

// ----- design/mmd_checker.sv -----
// ----------------------------------------------------------------------------
// mmd_checker
// Port-level checks on the min/max decimator, bound to the top level.
// ----------------------------------------------------------------------------
module mmd_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_kind
);
  import mmd_pkg::*;

  logic out_xfer;
  assign out_xfer = out_valid && out_ready;

  // hold a result until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown after reset");

  a_min_then_max: assert property (@(posedge clk) disable iff (rst)
    out_xfer && out_kind == KIND_MIN |=> out_valid && out_kind == KIND_MAX)
    else $error("bucket maximum does not follow minimum");

  a_max_then_boundary: assert property (@(posedge clk) disable iff (rst)
    out_xfer && out_kind == KIND_MAX |=> out_valid && out_kind == KIND_BOUNDARY)
    else $error("boundary sample does not follow maximum");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("sample taken while result register is stalled");

endmodule

bind min_max_decimator mmd_checker u_mmd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (samples.ready),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .out_kind  (results.kind)
);

// ----- tb/tb_min_max_decimator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_min_max_decimator
// Self-checking bench for the min/max decimator. A short table of directed
// rows (register writes and samples) runs first. Random phases follow, each
// with fresh register settings and one of three channel idling mixes. Every
// sample transfer is fed to a bit-exact bucket model in the bench. Each
// result transfer is checked against the oldest expected result.
// ----------------------------------------------------------------------------
module tb_min_max_decimator;
  import mmd_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_op_t;

  typedef struct packed {
    logic [15:0] value;
    kind_t       kind;
    logic        last;
  } result_t;

  typedef struct packed {
    row_op_t     op;
    reg_index_t  idx;
    logic [23:0] data;
    logic [15:0] s;
    logic        eos;
    logic        typed;
    result_t     want;
  } stim_row_t;

  logic                       clk;
  logic                       rst;
  logic                       cfg_write;
  logic [REG_INDEX_WIDTH-1:0] cfg_index;
  logic [23:0]                cfg_data;

  mmd_sample_if #(.SAMPLE_WIDTH(16)) sample_ch ();
  mmd_result_if #(.SAMPLE_WIDTH(16)) result_ch ();

  min_max_decimator #(
    .SAMPLE_WIDTH   (16),
    .POSITION_WIDTH (24)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .samples   (sample_ch),
    .results   (result_ch)
  );

  // register copies
  logic        agg_mode;
  logic        cmp_unsigned;
  logic [15:0] n_buckets;
  logic [23:0] whole_step;
  logic [15:0] rem_step;

  // window state
  logic [23:0] pos;
  logic [23:0] bnd_whole;
  logic [15:0] bnd_rem;
  logic [15:0] bnd_index;
  logic [15:0] win_min;
  logic [15:0] win_max;
  logic        win_started;
  logic        win_done;

  result_t burst [3];
  result_t expected_q [$];
  int      errors;
  int      src_idle_pct;
  int      sink_idle_pct;
  int      quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] order_of(input logic [15:0] s);
    return cmp_unsigned ? s : (s ^ 16'h8000);
  endfunction

  function automatic void next_boundary();
    logic [15:0] r;
    logic [16:0] acc;
    r = rem_step;
    if (n_buckets != 16'd0 && r >= n_buckets) r = n_buckets - 16'd1;
    bnd_whole = bnd_whole + whole_step;
    acc = {1'b0, bnd_rem} + {1'b0, r};
    if (acc >= {1'b0, n_buckets}) begin
      acc = acc - {1'b0, n_buckets};
      bnd_whole = bnd_whole + 24'd1;
    end
    bnd_rem = acc[15:0];
  endfunction

  function automatic logic [23:0] boundary_at();
    logic [16:0] twice;
    logic        up;
    twice = {bnd_rem, 1'b0};
    up = (twice > {1'b0, n_buckets}) ||
         (twice == {1'b0, n_buckets} && twice != 17'd0 && bnd_whole[0]);
    return bnd_whole + {23'd0, up};
  endfunction

  function automatic int decimate(input logic [15:0] s, input logic eos);
    logic closing;
    if (!agg_mode) begin
      burst[0] = '{s, KIND_PASS, eos};
      return 1;
    end
    if (win_done) return 0;
    if (!win_started) begin
      win_started = 1'b1;
      win_min = s;
      win_max = s;
      pos = 24'd1;
      bnd_whole = 24'd0;
      bnd_rem = 16'd0;
      if (n_buckets == 16'd0) begin
        win_done = 1'b1;
        burst[0] = '{s, KIND_FIRST, 1'b1};
      end else begin
        bnd_index = 16'd1;
        next_boundary();
        burst[0] = '{s, KIND_FIRST, 1'b0};
      end
      return 1;
    end
    if (pos >= boundary_at()) begin
      closing = (bnd_index >= n_buckets);
      burst[0] = '{win_min, KIND_MIN, 1'b0};
      burst[1] = '{win_max, KIND_MAX, 1'b0};
      burst[2] = '{s, KIND_BOUNDARY, closing};
      win_min = s;
      win_max = s;
      if (closing) begin
        win_done = 1'b1;
      end else begin
        bnd_index = bnd_index + 16'd1;
        next_boundary();
      end
      pos = pos + 24'd1;
      return 3;
    end
    if (order_of(s) < order_of(win_min)) win_min = s;
    if (order_of(s) > order_of(win_max)) win_max = s;
    pos = pos + 24'd1;
    return 0;
  endfunction

  function automatic stim_row_t wr(input reg_index_t idx, input logic [23:0] data);
    stim_row_t r;
    r = '0;
    r.op = ROW_WRITE;
    r.idx = idx;
    r.data = data;
    return r;
  endfunction

  function automatic stim_row_t smp(input logic [15:0] s, input logic eos);
    stim_row_t r;
    r = '0;
    r.op = ROW_SAMPLE;
    r.s = s;
    r.eos = eos;
    return r;
  endfunction

  function automatic stim_row_t pin(input logic [15:0] s, input logic eos,
                                    input kind_t kind, input logic last);
    stim_row_t r;
    r = smp(s, eos);
    r.typed = 1'b1;
    r.want = '{s, kind, last};
    return r;
  endfunction

  function automatic logic [15:0] pick_sample();
    logic [15:0] corners [4];
    corners = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF};
    if ($urandom_range(7) == 0) return corners[$urandom_range(3)];
    return 16'($urandom_range(0, 65535));
  endfunction

  task automatic settle();
    @(negedge clk);
    sample_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [23:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_AGGREGATE_MODE:   agg_mode = data[0];
      REG_SAMPLES_UNSIGNED: cmp_unsigned = data[0];
      REG_BUCKET_COUNT:     n_buckets = data[15:0];
      REG_STEP_WHOLE:       whole_step = data;
      REG_STEP_REMAINDER:   rem_step = data[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic send_sample(input logic [15:0] s, input logic eos,
                             input logic typed, input result_t want);
    int n;
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(negedge clk);
    end
    sample_ch.valid         <= 1'b1;
    sample_ch.sample        <= s;
    sample_ch.end_of_stream <= eos;
    // hold until the transfer
    do @(posedge clk); while (!sample_ch.ready);
    n = decimate(s, eos);
    if (typed) begin
      expected_q.push_back(want);
    end else begin
      for (int i = 0; i < n; i++) expected_q.push_back(burst[i]);
    end
  endtask

  always @(negedge clk) begin
    result_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk) begin : check_results
    result_t want;
    result_t got;
    if (!rst) begin
      if (result_ch.valid && result_ch.ready) begin
        got = '{result_ch.value, kind_t'(result_ch.kind), result_ch.last};
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got value %h kind %0d last %b",
                   $time, got.value, got.kind, got.last);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (got.value !== want.value || got.kind !== want.kind ||
              got.last !== want.last) begin
            $display("%0t: mismatch, expected value %h kind %0d last %b, got value %h kind %0d last %b",
                     $time, want.value, want.kind, want.last,
                     got.value, got.kind, got.last);
            errors++;
          end
        end
      end
      if ((result_ch.valid && result_ch.ready) || (sample_ch.valid && sample_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("%0t: watchdog expired with %0d results outstanding",
                   $time, expected_q.size());
          $display("*** FAILED ***");
          $finish;
        end
      end
    end
  end

  initial begin
    stim_row_t   rows [$];
    logic [15:0] count;
    logic [15:0] rem;

    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_AGGREGATE_MODE;
    cfg_data = 24'd0;
    sample_ch.valid = 1'b0;
    sample_ch.sample = 16'd0;
    sample_ch.end_of_stream = 1'b0;
    result_ch.ready = 1'b0;
    agg_mode = 1'b1;
    cmp_unsigned = 1'b0;
    n_buckets = 16'd1;
    whole_step = 24'd1;
    rem_step = 16'd0;
    pos = '0;
    bnd_whole = '0;
    bnd_rem = '0;
    bnd_index = '0;
    win_min = '0;
    win_max = '0;
    win_started = 1'b0;
    win_done = 1'b0;
    errors = 0;
    quiet_cycles = 0;
    src_idle_pct = 21;
    sink_idle_pct = 83;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    rows.push_back(wr(REG_AGGREGATE_MODE, 24'd1));
    rows.push_back(wr(REG_SAMPLES_UNSIGNED, 24'd0));
    rows.push_back(wr(REG_BUCKET_COUNT, 24'd65535));
    rows.push_back(wr(REG_STEP_WHOLE, 24'd3));
    rows.push_back(wr(REG_STEP_REMAINDER, 24'd65534));
    rows.push_back(pin(16'h8000, 1'b0, KIND_FIRST, 1'b0));
    rows.push_back(smp(16'h7FFF, 1'b0));
    rows.push_back(smp(16'h0000, 1'b1));
    rows.push_back(smp(16'hFFFF, 1'b0));
    rows.push_back(smp(16'h0001, 1'b0));
    rows.push_back(smp(16'h8000, 1'b0));
    rows.push_back(smp(16'h7FFE, 1'b0));
    rows.push_back(wr(REG_SAMPLES_UNSIGNED, 24'd1));
    rows.push_back(smp(16'hFFFF, 1'b0));
    rows.push_back(smp(16'h0000, 1'b0));
    rows.push_back(smp(16'h7FFF, 1'b1));
    rows.push_back(smp(16'h8000, 1'b0));
    rows.push_back(smp(16'h1234, 1'b0));
    rows.push_back(wr(REG_AGGREGATE_MODE, 24'd0));
    rows.push_back(pin(16'hFFFF, 1'b1, KIND_PASS, 1'b1));
    rows.push_back(pin(16'h0000, 1'b0, KIND_PASS, 1'b0));
    rows.push_back(wr(REG_AGGREGATE_MODE, 24'd1));
    rows.push_back(wr(REG_STEP_WHOLE, 24'd0));
    rows.push_back(wr(REG_STEP_REMAINDER, 24'd0));
    rows.push_back(smp(16'h5555, 1'b0));
    rows.push_back(smp(16'hAAAA, 1'b1));
    rows.push_back(wr(REG_STEP_REMAINDER, 24'hFFFF));
    rows.push_back(smp(16'h0F0F, 1'b0));
    rows.push_back(smp(16'hF0F0, 1'b0));
    rows.push_back(smp(16'h0000, 1'b0));
    rows.push_back(wr(REG_STEP_WHOLE, 24'hFFFFFF));
    rows.push_back(smp(16'h8001, 1'b0));
    rows.push_back(smp(16'h7FFF, 1'b0));
    rows.push_back(wr(REG_STEP_WHOLE, 24'd2));

    foreach (rows[i]) begin
      if (rows[i].op == ROW_WRITE) begin
        settle();
        write_reg(rows[i].idx, rows[i].data);
      end else begin
        send_sample(rows[i].s, rows[i].eos, rows[i].typed, rows[i].want);
      end
    end

    for (int phase = 0; phase < 9; phase++) begin
      src_idle_pct  = (phase < 3) ? 21 : (phase < 6) ? 83 : 0;
      sink_idle_pct = (phase < 3) ? 83 : (phase < 6) ? 21 : 0;
      settle();
      count = 16'($urandom_range(2000, 65535));
      if ($urandom_range(3) == 0) begin
        // even count with half remainder lands on ties
        count[0] = 1'b0;
        rem = count >> 1;
      end else if ($urandom_range(7) == 0) begin
        rem = 16'($urandom_range(count, 65535));
      end else begin
        rem = 16'($urandom_range(0, count - 16'd1));
      end
      write_reg(REG_BUCKET_COUNT, {8'd0, count});
      write_reg(REG_STEP_WHOLE, 24'($urandom_range(0, 5)));
      write_reg(REG_STEP_REMAINDER, {8'd0, rem});
      write_reg(REG_SAMPLES_UNSIGNED, 24'($urandom_range(1)));
      write_reg(REG_AGGREGATE_MODE, {23'd0, phase != 4});
      repeat (45) send_sample(pick_sample(), 1'($urandom_range(1)), 1'b0, '0);
    end

    // drop the bucket count below the index to close the window
    settle();
    write_reg(REG_BUCKET_COUNT, 24'd0);
    write_reg(REG_STEP_WHOLE, 24'd1);
    write_reg(REG_AGGREGATE_MODE, 24'd1);
    while (!win_done) send_sample(pick_sample(), 1'($urandom_range(1)), 1'b0, '0);
    repeat (12) send_sample(pick_sample(), 1'($urandom_range(1)), 1'b0, '0);
    settle();
    write_reg(REG_AGGREGATE_MODE, 24'd0);
    repeat (20) send_sample(pick_sample(), 1'($urandom_range(1)), 1'b0, '0);
    settle();

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
